// ----- rtl/core/sha256_pkg.sv -----
// Shared types, constants and the rotate-right helper for the SHA-256 digest block.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } item_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/core/sha256_fifo.sv -----
// Short queue of requests between the front and back parts.
module sha256_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_stall,
  input  sha256_pkg::item_t    wr_item,
  output logic                 rd_valid,
  input  logic                 rd_take,
  output sha256_pkg::item_t    rd_item
);

  sha256_pkg::item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ----- rtl/core/sha256_core.sv -----
// Back part: block buffer, padding sequencer and one-round-per-cycle compression.
module sha256_core #(
  parameter int LCB = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_take,
  input  sha256_pkg::item_t item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_digest_0,
  output logic [63:0]       out_digest_1,
  output logic [63:0]       out_digest_2,
  output logic [63:0]       out_digest_3
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;

  logic [2:0]      st_r, st_nxt;
  logic [31:0]     blk_r [16];
  logic [31:0]     h_r [8];
  logic [31:0]     v_r [8];
  logic [31:0]     w_r [16];
  logic [LCB-1:0]  len_r;
  logic [LCB-1:0]  len_inc;
  logic [63:0]     bits_r;
  logic [6:0]      rnd_r;
  logic [5:0]      pp_r;
  logic            fin_r;
  logic            second_r;
  logic [63:0]     dg_r [4];
  logic            ov_r;

  logic [5:0]  pos;
  logic [31:0] wnew, wr, s0, s1, ch, mj, t1, t2, x15, x2, e0, e1;

  assign pos       = len_r[8:3];
  assign len_inc   = len_r + LCB'(8);
  assign item_take = (st_r == S_IDLE) && item_valid && !(item.last && ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_digest_0 = dg_r[0];
  assign out_digest_1 = dg_r[1];
  assign out_digest_2 = dg_r[2];
  assign out_digest_3 = dg_r[3];

  always_comb begin
    x15  = w_r[1];
    x2   = w_r[14];
    e0   = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
    e1   = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
    wnew = w_r[0] + e0 + w_r[9] + e1;
    wr   = w_r[0];
    s1   = sha256_pkg::rotr(v_r[4], 6) ^ sha256_pkg::rotr(v_r[4], 11)
         ^ sha256_pkg::rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + s1 + ch + sha256_pkg::ROUND_K[rnd_r[5:0]] + wr;
    s0   = sha256_pkg::rotr(v_r[0], 2) ^ sha256_pkg::rotr(v_r[0], 13)
         ^ sha256_pkg::rotr(v_r[0], 22);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = s0 + mj;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (item_take && ((item.byte_valid && pos == 6'd63) || item.last)) begin
        st_nxt = (item.byte_valid && pos == 6'd63) ? S_LOAD : S_PAD;
      end
      S_PAD:  if (pp_r == 6'd63) st_nxt = S_LOAD;
      S_LOAD: st_nxt = S_RND;
      S_RND:  if (rnd_r == 7'd63) st_nxt = S_ADD;
      S_ADD:  st_nxt = (fin_r && !second_r) ? S_PAD : S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Block buffer; during padding one byte per cycle is written.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && item_take && item.byte_valid) begin
      blk_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= item.data_byte;
    end else if (st_r == S_PAD) begin
      if (!second_r && pp_r == bits_r[8:3]) begin
        blk_r[pp_r[5:2]][{~pp_r[1:0], 3'b000} +: 8] <= sha256_pkg::PAD_BYTE;
      end else if (pp_r >= sha256_pkg::LEN_POS && (second_r || bits_r[8:3] < 6'd56)) begin
        blk_r[pp_r[5:2]][{~pp_r[1:0], 3'b000} +: 8] <= bits_r[8'd63 - {pp_r[2:0], 3'd0} -: 8];
      end else begin
        blk_r[pp_r[5:2]][{~pp_r[1:0], 3'b000} +: 8] <= 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_LOAD) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= blk_r[i];
      end
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (st_r == S_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_ADD && fin_r && second_r) begin
      for (int i = 0; i < 4; i++) begin
        dg_r[i] <= {h_r[2*i] + v_r[2*i], h_r[2*i+1] + v_r[2*i+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      len_r    <= '0;
      bits_r   <= '0;
      rnd_r    <= '0;
      pp_r     <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      ov_r     <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (item_take) begin
          if (item.byte_valid) len_r <= len_inc;
          if (item.last) begin
            fin_r    <= 1'b1;
            second_r <= 1'b0;
            pp_r     <= item.byte_valid ? pos + 6'd1 : pos;
            bits_r   <= 64'(item.byte_valid ? len_inc : len_r);
          end else begin
            fin_r <= 1'b0;
          end
        end
        S_PAD: begin
          pp_r <= pp_r + 6'd1;
          if (pp_r == 6'd63 && bits_r[8:3] < 6'd56) second_r <= 1'b1;
        end
        S_LOAD: rnd_r <= '0;
        S_RND:  rnd_r <= rnd_r + 7'd1;
        S_ADD: begin
          if (fin_r && second_r) begin
            for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::INIT_H[i];
            len_r <= '0;
            ov_r  <= 1'b1;
            fin_r <= 1'b0;
          end else begin
            for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
            if (fin_r) begin
              pp_r     <= '0;
              second_r <= bits_r[8:3] >= 6'd56 ? 1'b1 : second_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sha256_message_digest.sv -----
// Top level of the streaming SHA-256 digest block.
// A request is registered in the two-entry queue before the core takes it.
// A byte that fills a 64-byte block holds the core through load, 64 rounds and add.
// A last request with n bytes in its block pads the rest of that block, then compresses it;
// with n of 56 or more a second block is padded and compressed as well. One request at a time.
// Synchronous active-low reset restores the initial hash values and zero length.
module sha256_message_digest #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_0,
  output logic [63:0] out_digest_1,
  output logic [63:0] out_digest_2,
  output logic [63:0] out_digest_3
);

  sha256_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  assign in_item = '{data_byte: in_data_byte, byte_valid: in_byte_valid, last: in_last};

  sha256_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid (in_valid), .wr_stall (in_stall), .wr_item (in_item),
    .rd_valid (q_valid), .rd_take (q_take), .rd_item (q_item)
  );

  sha256_core #(.LCB(LENGTH_COUNTER_BITS)) u_core (
    .clk, .rst_n,
    .item_valid (q_valid), .item_take (q_take), .item (q_item),
    .out_valid, .out_stall,
    .out_digest_0, .out_digest_1, .out_digest_2, .out_digest_3
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_0))
    else $error("digest changed while stalled");
  a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("core took from empty queue");

endmodule
